// ----- hw/rtl/vfd_pkg.sv -----
// Shared types and constants for the varint frame deframer.
package vfd_pkg;

    localparam int unsigned VAL_W      = 62;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned VLEFT_W    = 3;
    localparam int unsigned ROLE_W     = 2;
    localparam int unsigned IN_DATA_W  = 8;
    // frame_type, payload_length, header_done, payload_byte, status = 134 bits
    localparam int unsigned OUT_RAW_W  = 2 * VAL_W + 1 + BYTE_W + 1;
    localparam int unsigned OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_LEN  = 2'd1,
        PH_PAY  = 2'd2
    } phase_t;

    typedef enum logic [ROLE_W-1:0] {
        ROLE_TYPE = 2'd0,
        ROLE_LEN  = 2'd1,
        ROLE_PAY  = 2'd2
    } role_t;

    typedef struct packed {
        role_t              byte_role;
        logic [VAL_W-1:0]   frame_type;
        logic [VAL_W-1:0]   payload_length;
        logic               header_done;
        logic [BYTE_W-1:0]  payload_byte;
        logic               frame_end;
        logic               status;
    } result_t;

    // Bytes still due after the first byte of a varint, from its size prefix.
    function automatic logic [VLEFT_W-1:0] varint_rest(input logic [1:0] prefix);
        logic [VLEFT_W-1:0] rest;
        case (prefix)
            2'b00:   rest = 3'd0;
            2'b01:   rest = 3'd1;
            2'b10:   rest = 3'd3;
            default: rest = 3'd7;
        endcase
        return rest;
    endfunction

endpackage

// ----- hw/rtl/vfd_parser.sv -----
// Frame parser state and the per-byte result logic.
module vfd_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     take,
    input  logic [vfd_pkg::BYTE_W-1:0] data_byte,
    input  logic                     buffer_end,
    output vfd_pkg::result_t         result
);
    import vfd_pkg::*;

    phase_t             phase_reg,   phase_next;
    logic [VLEFT_W-1:0] vleft_reg,   vleft_next;
    logic [VAL_W-1:0]   acc_reg,     acc_next;
    logic [VAL_W-1:0]   held_reg,    held_next;
    logic [VAL_W-1:0]   pay_reg,     pay_next;

    logic               first_byte;
    logic [VAL_W-1:0]   vacc_step;
    logic [VLEFT_W-1:0] vleft_step;
    logic               vdone;
    logic [VAL_W-1:0]   pay_dec;

    assign first_byte = (vleft_reg == '0);
    assign vacc_step  = first_byte ? {{(VAL_W-6){1'b0}}, data_byte[5:0]}
                                   : {acc_reg[VAL_W-BYTE_W-1:0], data_byte};
    assign vleft_step = first_byte ? varint_rest(data_byte[7:6])
                                   : vleft_reg - 1'b1;
    assign vdone      = (vleft_step == '0);
    assign pay_dec    = pay_reg - 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        vleft_next = vleft_reg;
        acc_next   = acc_reg;
        held_next  = held_reg;
        pay_next   = pay_reg;
        result     = '0;

        case (phase_reg)
            PH_PAY:
            begin
                result.byte_role      = ROLE_PAY;
                result.payload_byte   = data_byte;
                result.frame_type     = held_reg;
                result.payload_length = acc_reg;
                pay_next              = pay_dec;
                if (pay_dec == '0)
                begin
                    result.frame_end = 1'b1;
                    phase_next       = PH_TYPE;
                end
            end
            PH_LEN:
            begin
                result.byte_role  = ROLE_LEN;
                result.frame_type = held_reg;
                acc_next          = vacc_step;
                vleft_next        = vleft_step;
                if (vdone)
                begin
                    result.header_done    = 1'b1;
                    result.payload_length = vacc_step;
                    pay_next              = vacc_step;
                    if (vacc_step == '0)
                    begin
                        result.frame_end = 1'b1;
                        phase_next       = PH_TYPE;
                    end
                    else
                    begin
                        phase_next = PH_PAY;
                    end
                end
            end
            default:
            begin
                // unused phase code behaves as the type phase
                result.byte_role = ROLE_TYPE;
                phase_next       = PH_TYPE;
                acc_next         = vacc_step;
                vleft_next       = vleft_step;
                if (vdone)
                begin
                    held_next         = vacc_step;
                    result.frame_type = vacc_step;
                    acc_next          = '0;
                    phase_next        = PH_LEN;
                end
            end
        endcase

        // buffer ran out inside a frame: flag it and start over
        if (buffer_end && !result.frame_end)
        begin
            result.status = 1'b1;
            phase_next    = PH_TYPE;
            vleft_next    = '0;
            acc_next      = '0;
            held_next     = '0;
            pay_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            vleft_reg <= '0;
            acc_reg   <= '0;
            held_reg  <= '0;
            pay_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            vleft_reg <= vleft_next;
            acc_reg   <= acc_next;
            held_reg  <= held_next;
            pay_reg   <= pay_next;
        end
    end

endmodule

// ----- hw/rtl/vfd_out_reg.sv -----
// Result register with valid flag toward the output stream.
module vfd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  vfd_pkg::result_t result,
    input  logic             out_ready,
    output logic             out_valid,
    output logic             can_load,
    output vfd_pkg::result_t held
);
    import vfd_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign held       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

endmodule

// ----- hw/rtl/varint_frame_deframer.sv -----
// Top level of the varint frame deframer.
//
//  channel  | dir | tdata                  | tuser     | tlast
//  s_axis   | in  | data_byte              | -         | buffer_end
//  m_axis   | out | type,len,hdr,byte,stat | byte_role | frame_end
//
// One byte in, one result out; a byte is taken every cycle as long as the
// result register is empty or being drained in the same cycle. Results are
// registered: m_tvalid rises in the cycle after a byte is taken. The parser
// state (phase, varint and payload counters) updates as the byte is taken.
// rst_n clears the parser to its start-of-frame state and empties the
// result register. A stall on m_tready holds the result and drops s_tready.
module varint_frame_deframer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [vfd_pkg::IN_DATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,   // buffer_end
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [61:0] frame_type, [123:62] payload_length, [124] header_done,
    // [132:125] payload_byte, [133] status, [135:134] zero
    output logic [vfd_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [vfd_pkg::ROLE_W-1:0]     m_tuser,   // [1:0] byte_role
    output logic                           m_tlast    // frame_end
);
    import vfd_pkg::*;

    logic    take;
    logic    can_load;
    result_t step_res;
    result_t out_res;

    assign s_tready = can_load;
    assign take     = s_tvalid && can_load;

    vfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (s_tdata[BYTE_W-1:0]),
        .buffer_end (s_tlast),
        .result     (step_res)
    );

    vfd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .result    (step_res),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .can_load  (can_load),
        .held      (out_res)
    );

    assign m_tdata = {{(OUT_DATA_W-OUT_RAW_W){1'b0}},
                      out_res.status,
                      out_res.payload_byte,
                      out_res.header_done,
                      out_res.payload_length,
                      out_res.frame_type};
    assign m_tuser = out_res.byte_role;
    assign m_tlast = out_res.frame_end;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Testbench for varint_frame_deframer: directed table plus random frame traffic.
module tb;
    import vfd_pkg::*;

    localparam int unsigned N_ITEMS   = 1700;
    localparam int unsigned CALM_FROM = 1500;
    localparam int unsigned DOG_LIMIT = 2000;
    localparam logic [VAL_W-1:0] V_MAX = '1;

    typedef struct {
        logic [7:0] b;
        logic       last;
        bit         typed;
        result_t    want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [ROLE_W-1:0]     m_tuser;
    logic                  m_tlast;

    // parser shadow state
    phase_t             pr_phase;
    logic [VLEFT_W-1:0] pr_vleft;
    logic [VAL_W-1:0]   pr_acc;
    logic [VAL_W-1:0]   pr_type;
    logic [VAL_W-1:0]   pr_left;

    result_t  pending_results[$];
    dir_row_t dir_rows[$];
    result_t  rx_item;
    bit       idle_on = 1'b1;
    int       rx_stall = 0;
    int       errors = 0;
    int       items_sent = 0;
    int       n_results = 0;
    int       n_frames = 0;
    int       n_trunc = 0;
    int       dog = 0;

    varint_frame_deframer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void clear_parser();
        pr_phase = PH_TYPE;
        pr_vleft = '0;
        pr_acc   = '0;
        pr_type  = '0;
        pr_left  = '0;
    endfunction

    // Shifts one byte into the running varint; returns 1 when it is complete.
    function automatic bit feed_varint(logic [7:0] b);
        if (pr_vleft == 0)
        begin
            pr_acc   = VAL_W'(b[5:0]);
            pr_vleft = VLEFT_W'((4'd1 << b[7:6]) - 4'd1);
        end
        else
        begin
            pr_acc   = {pr_acc[VAL_W-9:0], b};
            pr_vleft = pr_vleft - 1'b1;
        end
        return pr_vleft == 0;
    endfunction

    function automatic result_t parse_byte(logic [7:0] b, logic last);
        result_t r;
        r = '0;
        case (pr_phase)
            PH_PAY:
            begin
                r.byte_role      = ROLE_PAY;
                r.payload_byte   = b;
                r.frame_type     = pr_type;
                r.payload_length = pr_acc;
                pr_left = pr_left - 1'b1;
                if (pr_left == 0)
                begin
                    r.frame_end = 1'b1;
                    pr_phase    = PH_TYPE;
                end
            end
            PH_LEN:
            begin
                r.byte_role  = ROLE_LEN;
                r.frame_type = pr_type;
                if (feed_varint(b))
                begin
                    r.header_done    = 1'b1;
                    r.payload_length = pr_acc;
                    pr_left          = pr_acc;
                    if (pr_acc == 0)
                    begin
                        r.frame_end = 1'b1;
                        pr_phase    = PH_TYPE;
                    end
                    else
                        pr_phase = PH_PAY;
                end
            end
            default:
            begin
                r.byte_role = ROLE_TYPE;
                pr_phase    = PH_TYPE;
                if (feed_varint(b))
                begin
                    pr_type      = pr_acc;
                    r.frame_type = pr_acc;
                    pr_acc       = '0;
                    pr_phase     = PH_LEN;
                end
            end
        endcase
        // buffer end inside a frame: flag it and start over
        if (last && !r.frame_end)
        begin
            r.status = 1'b1;
            clear_parser();
        end
        return r;
    endfunction

    function automatic result_t rv(role_t ro, logic [VAL_W-1:0] ft, logic [VAL_W-1:0] pl,
                                   logic hd, logic [7:0] pb, logic fe, logic st);
        result_t r;
        r.byte_role      = ro;
        r.frame_type     = ft;
        r.payload_length = pl;
        r.header_done    = hd;
        r.payload_byte   = pb;
        r.frame_end      = fe;
        r.status         = st;
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] rand62();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[VAL_W-1:0];
    endfunction

    task automatic add_row(logic [7:0] b, logic last, bit typed, result_t want);
        dir_row_t row;
        row.b     = b;
        row.last  = last;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // Offers one byte and waits until it is taken.
    task automatic send_byte(logic [7:0] b, logic last, bit typed, result_t want);
        result_t pred;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        pred = parse_byte(b, last);
        pending_results.push_back(typed ? want : pred);
    endtask

    // Appends a varint of 1 << sc bytes holding v (cut to fit).
    task automatic put_varint(ref logic [7:0] q[$], input int sc, input logic [VAL_W-1:0] v);
        int nb;
        logic [63:0] w;
        nb = 1 << sc;
        w  = 64'(v) & ((64'd1 << (8 * nb - 2)) - 64'd1);
        w  = w | (64'(sc) << (8 * nb - 2));
        for (int i = nb - 1; i >= 0; i--)
            q.push_back(w[8*i +: 8]);
    endtask

    task automatic send_frame();
        logic [7:0] fb[$];
        int kind;
        int pick;
        int sc;
        int min_sc;
        int len;
        int cut;
        int stop;
        kind = $urandom_range(0, 19);
        if (kind == 0)
        begin
            // noise burst, closed by a buffer end so the parser recovers
            repeat ($urandom_range(1, 12)) fb.push_back(8'($urandom));
            cut = fb.size() - 1;
        end
        else if (kind == 1)
        begin
            // wide length field, cut short inside the payload
            put_varint(fb, $urandom_range(0, 3), rand62());
            put_varint(fb, $urandom_range(1, 3), rand62() | (62'd1 << 13));
            repeat ($urandom_range(1, 4)) fb.push_back(8'($urandom));
            cut = fb.size() - 1;
        end
        else
        begin
            pick = $urandom_range(0, 19);
            sc   = (pick < 10) ? 0 : (pick < 14) ? 1 : (pick < 17) ? 2 : 3;
            put_varint(fb, sc, rand62());
            pick = $urandom_range(0, 19);
            if (pick < 15)
                len = $urandom_range(0, 8);
            else if (pick < 19)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(41, 300);
            min_sc = (len < 64) ? 0 : 1;
            sc = ($urandom_range(0, 4) < 3) ? min_sc : $urandom_range(min_sc, 3);
            put_varint(fb, sc, VAL_W'(len));
            repeat (len) fb.push_back(8'($urandom));
            if ($urandom_range(0, 11) == 0)
                cut = $urandom_range(0, fb.size() - 1);
            else if ($urandom_range(0, 3) == 0)
                cut = fb.size() - 1;
            else
                cut = -1;
        end
        stop = (cut >= 0) ? cut : fb.size() - 1;
        for (int i = 0; i <= stop; i++)
            send_byte(fb[i], i == cut, 1'b0, '0);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    // result side: check each accepted item, stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                rx_item.byte_role      = role_t'(m_tuser);
                rx_item.frame_type     = m_tdata[61:0];
                rx_item.payload_length = m_tdata[123:62];
                rx_item.header_done    = m_tdata[124];
                rx_item.payload_byte   = m_tdata[132:125];
                rx_item.status         = m_tdata[133];
                rx_item.frame_end      = m_tlast;
                n_results++;
                if (m_tlast)
                    n_frames++;
                if (m_tdata[133])
                    n_trunc++;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected: role %0d type 0x%0h",
                             $time, rx_item.byte_role, rx_item.frame_type);
                end
                else
                begin
                    result_t want;
                    want = pending_results.pop_front();
                    check_field("byte_role", 64'(want.byte_role), 64'(rx_item.byte_role));
                    check_field("frame_type", 64'(want.frame_type), 64'(rx_item.frame_type));
                    check_field("payload_length", 64'(want.payload_length),
                                64'(rx_item.payload_length));
                    check_field("header_done", 64'(want.header_done), 64'(rx_item.header_done));
                    check_field("payload_byte", 64'(want.payload_byte),
                                64'(rx_item.payload_byte));
                    check_field("frame_end", 64'(want.frame_end), 64'(rx_item.frame_end));
                    check_field("status", 64'(want.status), 64'(rx_item.status));
                end
            end
            if (rx_stall > 0)
            begin
                rx_stall <= rx_stall - 1;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                rx_stall <= $urandom_range(1, 16) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog: too long without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                dog <= 0;
            else
                dog <= dog + 1;
            if (dog >= DOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, dog);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        bit paused;
        int seg_mark;
        paused   = 1'b0;
        seg_mark = 0;
        clear_parser();

        // short frames at the size extremes
        add_row(8'h00, 1'b0, 1'b1, rv(ROLE_TYPE, 0, 0, 0, 8'h00, 0, 0));
        add_row(8'h00, 1'b0, 1'b1, rv(ROLE_LEN, 0, 0, 1, 8'h00, 1, 0));
        add_row(8'h3F, 1'b0, 1'b1, rv(ROLE_TYPE, 63, 0, 0, 8'h00, 0, 0));
        add_row(8'h01, 1'b0, 1'b1, rv(ROLE_LEN, 63, 1, 1, 8'h00, 0, 0));
        add_row(8'hFF, 1'b0, 1'b1, rv(ROLE_PAY, 63, 1, 0, 8'hFF, 1, 0));
        // eight-byte type of all ones
        repeat (7) add_row(8'hFF, 1'b0, 1'b1, rv(ROLE_TYPE, 0, 0, 0, 8'h00, 0, 0));
        add_row(8'hFF, 1'b0, 1'b1, rv(ROLE_TYPE, V_MAX, 0, 0, 8'h00, 0, 0));
        add_row(8'h40, 1'b0, 1'b1, rv(ROLE_LEN, V_MAX, 0, 0, 8'h00, 0, 0));
        add_row(8'h02, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        // buffer end on the frame's last byte is not a truncation
        add_row(8'hA5, 1'b1, 1'b1, rv(ROLE_PAY, V_MAX, 2, 0, 8'hA5, 1, 0));
        // truncated inside the type varint
        add_row(8'h80, 1'b0, 1'b1, rv(ROLE_TYPE, 0, 0, 0, 8'h00, 0, 0));
        add_row(8'h12, 1'b1, 1'b1, rv(ROLE_TYPE, 0, 0, 0, 8'h00, 0, 1));
        // truncated inside the payload
        add_row(8'h05, 1'b0, 1'b0, '0);
        add_row(8'h03, 1'b0, 1'b0, '0);
        add_row(8'h11, 1'b1, 1'b1, rv(ROLE_PAY, 5, 3, 0, 8'h11, 0, 1));
        // truncated right after a complete type
        add_row(8'h07, 1'b1, 1'b1, rv(ROLE_TYPE, 7, 0, 0, 8'h00, 0, 1));
        // truncated on the first byte of an eight-byte length
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b1, 1'b1, rv(ROLE_LEN, 0, 0, 0, 8'h00, 0, 1));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);

        while (items_sent < N_ITEMS)
        begin
            if (items_sent >= CALM_FROM)
                idle_on = 1'b0;
            else if (items_sent >= seg_mark)
            begin
                idle_on  = ($urandom_range(0, 3) != 0);
                seg_mark = seg_mark + 150;
            end
            if (!paused && items_sent >= N_ITEMS / 2)
            begin
                // hold off until the output side has caught up completely
                paused = 1'b1;
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
            end
            send_frame();
        end

        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes, checked %0d results: %0d frames closed, %0d truncations.",
                 items_sent, n_results, n_frames, n_trunc);
        $display("Varints of every size, empty and long payloads, noise, stalls on both sides.");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
